[src/jct_pkg.sv]
// shared types and constants for the job credit table update block
// no dependencies; used by every module under src except jct_ram

package jct_pkg;

    localparam int MACH_W = 3;
    localparam int JOB_W  = 32;
    localparam int CRED_W = 8;
    localparam int SLOT_W = 4;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_NONE       = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE     = 2'd1;
    localparam logic [OP_W-1:0] OP_INVALIDATE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic rd;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

[src/jct_ram.sv]
// generic single write port ram with registered read
// no dependencies

module jct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/jct_ctrl.sv]
// controller state machine: accept, row read, execute and write back
// depends on jct_pkg

module jct_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  jct_pkg::t_status i_status,
    output jct_pkg::t_cmd    o_cmd
);

    jct_pkg::t_state r_state;
    jct_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jct_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            jct_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = jct_pkg::ST_READ;
                end
            end
            jct_pkg::ST_READ: begin
                n_state = jct_pkg::ST_EXEC;
            end
            jct_pkg::ST_EXEC: begin
                // wait until the output register can take the result
                if (!i_status.out_busy) begin
                    n_state = jct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jct_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.rd      = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            jct_pkg::ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            jct_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            jct_pkg::ST_EXEC: begin
                o_cmd.exec = !i_status.out_busy;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

[src/jct_dp.sv]
// datapath: per machine row of slots, credits and free queue in a ram,
// slot search, credit decrement, queue push and pop, output register
// depends on jct_pkg and jct_ram

module jct_dp #(
    parameter int MACHINES = 5,
    parameter int SLOTS    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jct_pkg::t_cmd               i_cmd,
    output jct_pkg::t_status            o_status,
    input  logic [jct_pkg::MACH_W-1:0]  i_machine,
    input  logic [jct_pkg::JOB_W-1:0]   i_top_job,
    input  logic [jct_pkg::JOB_W-1:0]   i_new_job,
    input  logic [jct_pkg::CRED_W-1:0]  i_new_credit,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [jct_pkg::JOB_W-1:0]   o_job_id,
    output logic [jct_pkg::OP_W-1:0]    o_operation,
    output logic                        o_slot_freed
);

    localparam int AW = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int SW = jct_pkg::SLOT_W;
    localparam int RW = SLOTS * (jct_pkg::JOB_W + jct_pkg::CRED_W) + (SLOTS + 1) * SW + 2 * SW;
    localparam logic [SW-1:0] LAST_Q = SW'(SLOTS);

    typedef logic [SLOTS-1:0][jct_pkg::JOB_W-1:0]  t_jobs;
    typedef logic [SLOTS-1:0][jct_pkg::CRED_W-1:0] t_creds;
    typedef logic [SLOTS:0][SW-1:0]                t_queue;

    // captured item
    logic [jct_pkg::MACH_W-1:0] r_machine;
    logic [jct_pkg::JOB_W-1:0]  r_top;
    logic [jct_pkg::JOB_W-1:0]  r_nj;
    logic [jct_pkg::CRED_W-1:0] r_nc;

    logic [MACHINES-1:0] r_row_valid;
    logic                r_rd_valid;

    logic                       r_out_valid;
    logic [jct_pkg::JOB_W-1:0]  r_out_job;
    logic [jct_pkg::OP_W-1:0]   r_out_op;
    logic                       r_out_freed;

    logic          in_range;
    logic [AW-1:0] row_addr;
    logic [RW-1:0] ram_rdata;
    logic [RW-1:0] init_row;
    logic [RW-1:0] cur_row;
    logic [RW-1:0] wr_row;
    logic          ram_we;

    t_jobs          rd_jobs;
    t_creds         rd_cred;
    t_queue         rd_q;
    logic [SW-1:0]  rd_head;
    logic [SW-1:0]  rd_tail;

    t_jobs          wr_jobs;
    t_creds         wr_cred;
    t_queue         wr_q;
    logic [SW-1:0]  wr_head;
    logic [SW-1:0]  wr_tail;

    logic [SLOTS-1:0]          hit;
    logic [SLOTS-1:0]          hit_sel;
    logic [SW-1:0]             hit_idx;
    logic [jct_pkg::CRED_W-1:0] cur_cred;
    logic [jct_pkg::CRED_W-1:0] dec_cred;
    logic [SW-1:0]             next_tail;
    logic [SW-1:0]             pop_slot;

    logic [jct_pkg::JOB_W-1:0] res_job;
    logic [jct_pkg::OP_W-1:0]  res_op;
    logic                      res_freed;

    assign in_range = int'(r_machine) < MACHINES;
    assign row_addr = in_range ? AW'(r_machine) : '0;
    assign ram_we   = i_cmd.exec && in_range;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_machine <= i_machine;
            r_top     <= i_top_job;
            r_nj      <= i_new_job;
            r_nc      <= i_new_credit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_rd_valid <= in_range && r_row_valid[row_addr];
            end
            if (ram_we) begin
                r_row_valid[row_addr] <= 1'b1;
            end
        end
    end

    jct_ram #(
        .WIDTH (RW),
        .DEPTH (MACHINES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (row_addr),
        .i_wdata (wr_row),
        .i_re    (i_cmd.rd),
        .i_raddr (row_addr),
        .o_rdata (ram_rdata)
    );

    // a row never written reads as an empty table with a full free queue
    always_comb begin
        t_queue q0;
        for (int i = 0; i <= SLOTS; i++) begin
            q0[i] = (i < SLOTS) ? SW'(i) : '0;
        end
        init_row = {LAST_Q, SW'(0), q0, t_creds'('0), t_jobs'('0)};
    end

    assign cur_row = r_rd_valid ? ram_rdata : init_row;
    assign {rd_tail, rd_head, rd_q, rd_cred, rd_jobs} = cur_row;

    always_comb begin
        wr_jobs   = rd_jobs;
        wr_cred   = rd_cred;
        wr_q      = rd_q;
        wr_head   = rd_head;
        wr_tail   = rd_tail;
        res_job   = '0;
        res_op    = jct_pkg::OP_NONE;
        res_freed = 1'b0;
        hit_idx   = '0;
        cur_cred  = '0;
        pop_slot  = '0;

        for (int i = 0; i < SLOTS; i++) begin
            hit[i] = (r_top != '0) && (rd_jobs[i] == r_top);
        end
        // lowest matching slot wins
        hit_sel = hit & (~hit + 1'b1);
        for (int i = 0; i < SLOTS; i++) begin
            if (hit_sel[i]) begin
                hit_idx  = hit_idx | SW'(i);
                cur_cred = cur_cred | rd_cred[i];
            end
        end
        dec_cred  = cur_cred - 1'b1;
        next_tail = (rd_tail == LAST_Q) ? '0 : rd_tail + 1'b1;

        if (in_range && (hit != '0)) begin
            res_job = r_top;
            if (dec_cred == '0) begin
                res_op    = jct_pkg::OP_INVALIDATE;
                res_freed = 1'b1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit_sel[i]) begin
                        wr_jobs[i] = '0;
                        wr_cred[i] = '0;
                    end
                end
                // push refused when the queue is full
                if (next_tail != rd_head) begin
                    for (int i = 0; i <= SLOTS; i++) begin
                        if (rd_tail == SW'(i)) begin
                            wr_q[i] = hit_idx;
                        end
                    end
                    wr_tail = next_tail;
                end
            end else begin
                res_op = jct_pkg::OP_UPDATE;
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit_sel[i]) begin
                        wr_cred[i] = dec_cred;
                    end
                end
            end
        end

        // pop sees the queue after the push above
        if ((r_nj != '0) && (wr_head != wr_tail)) begin
            for (int i = 0; i <= SLOTS; i++) begin
                if (rd_head == SW'(i)) begin
                    pop_slot = wr_q[i];
                end
            end
            wr_head = (rd_head == LAST_Q) ? '0 : rd_head + 1'b1;
            // an out of range slot number is consumed and the job dropped
            for (int i = 0; i < SLOTS; i++) begin
                if (pop_slot == SW'(i)) begin
                    wr_jobs[i] = r_nj;
                    wr_cred[i] = r_nc;
                end
            end
        end

        wr_row = {wr_tail, wr_head, wr_q, wr_cred, wr_jobs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_job   <= res_job;
            r_out_op    <= res_op;
            r_out_freed <= res_freed;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_job_id          = r_out_job;
    assign o_operation       = r_out_op;
    assign o_slot_freed      = r_out_freed;

    a_we_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (i_cmd.exec && in_range))
        else $error("row write for a machine out of range");

    a_exec_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("executed item produced no result");

    a_freed_is_invalidate : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_freed) |-> ((r_out_op == jct_pkg::OP_INVALIDATE)
                                          && (r_out_job != '0)))
        else $error("freed slot reported without invalidate");

    a_ptr_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((wr_head <= LAST_Q) && (wr_tail <= LAST_Q)))
        else $error("free queue pointer beyond its depth");

    a_no_capture_while_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd || i_cmd.exec) |-> !i_cmd.capture)
        else $error("new item captured while one is in work");

endmodule

[src/job_credit_table_update.sv]
// job credit table update: one result per accepted item, registered on the master
// side after the item is captured and the machine's row is read from the table ram;
// a new item is taken only after the last one is done, set by the read-modify-write
// of the row (read, then search/decrement/queue and write back) and output stalls
// synchronous active-low reset; rows read as empty tables with full free queues
// until first written, through one valid flag per machine, so no clearing pass

module job_credit_table_update #(
    parameter int MACHINES = 5,
    parameter int SLOTS    = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // top_job[31:0], new_job[63:32], new_credit[71:64]
    input  logic [2:0]  s_tuser,   // machine[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // job_id[31:0]
    output logic [2:0]  m_tuser    // operation[1:0], slot_freed[2]
);

    jct_pkg::t_cmd    cmd;
    jct_pkg::t_status status;

    logic [jct_pkg::OP_W-1:0] operation;
    logic                     slot_freed;

    jct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    jct_dp #(
        .MACHINES (MACHINES),
        .SLOTS    (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_machine    (s_tuser),
        .i_top_job    (s_tdata[31:0]),
        .i_new_job    (s_tdata[63:32]),
        .i_new_credit (s_tdata[71:64]),
        .o_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .o_job_id     (m_tdata),
        .o_operation  (operation),
        .o_slot_freed (slot_freed)
    );

    assign m_tuser = {slot_freed, operation};

endmodule

[tb/testbench.sv]
// self-checking testbench for job_credit_table_update: per-machine credit tables and free-slot queues
// a scoreboard class predicts one result per tick; plain tasks drive the stream ports
// depends on src/jct_pkg.sv and src/job_credit_table_update.sv

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MACH_W = jct_pkg::MACH_W;
    localparam int JOB_W  = jct_pkg::JOB_W;
    localparam int CRED_W = jct_pkg::CRED_W;
    localparam int SLOT_W = jct_pkg::SLOT_W;
    localparam int OP_W   = jct_pkg::OP_W;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int ITEMS_PER_PHASE = 232;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        logic [MACH_W-1:0] machine;
        logic [JOB_W-1:0]  top_job;
        logic [JOB_W-1:0]  new_job;
        logic [CRED_W-1:0] new_credit;
    } t_tick_item;

    typedef struct {
        logic [JOB_W-1:0] job_id;
        logic [OP_W-1:0]  op;
        logic             freed;
    } t_tick_result;

    class credit_scoreboard;
        localparam int NMACH = 5;
        localparam int NSLOT = 10;
        localparam int QLEN  = NSLOT + 1;

        logic [JOB_W-1:0]  slot_job    [NMACH*NSLOT];
        logic [CRED_W-1:0] slot_credit [NMACH*NSLOT];
        logic [SLOT_W-1:0] free_slots  [NMACH*QLEN];
        logic [SLOT_W-1:0] q_head      [NMACH];
        logic [SLOT_W-1:0] q_tail      [NMACH];
        t_tick_result      expected_q  [$];
        int                errors;

        function new();
            errors = 0;
            for (int m = 0; m < NMACH; m++) begin
                for (int i = 0; i < NSLOT; i++) begin
                    slot_job[m*NSLOT+i]    = '0;
                    slot_credit[m*NSLOT+i] = '0;
                end
                for (int i = 0; i < QLEN; i++)
                    free_slots[m*QLEN+i] = (i < NSLOT) ? SLOT_W'(i) : '0;
                q_head[m] = '0;
                q_tail[m] = SLOT_W'(NSLOT);
            end
        endfunction

        function void note_item(t_tick_item it);
            int                m;
            int                idx;
            logic [CRED_W-1:0] c;
            logic [SLOT_W-1:0] nt;
            logic [SLOT_W-1:0] s;
            t_tick_result      r;
            r.job_id = '0;
            r.op     = jct_pkg::OP_NONE;
            r.freed  = 1'b0;
            if (it.machine < NMACH) begin
                m = it.machine;
                if (it.top_job != '0) begin
                    // lowest matching slot wins when ids repeat
                    for (int k = 0; k < NSLOT; k++) begin
                        idx = m*NSLOT + k;
                        if (slot_job[idx] == it.top_job) begin
                            c = slot_credit[idx] - 8'd1;
                            r.job_id = it.top_job;
                            if (c == '0) begin
                                slot_job[idx]    = '0;
                                slot_credit[idx] = '0;
                                nt = (q_tail[m] == NSLOT) ? '0 : q_tail[m] + 4'd1;
                                // a full queue drops the slot number
                                if (nt != q_head[m]) begin
                                    free_slots[m*QLEN+q_tail[m]] = SLOT_W'(k);
                                    q_tail[m] = nt;
                                end
                                r.op    = jct_pkg::OP_INVALIDATE;
                                r.freed = 1'b1;
                            end else begin
                                slot_credit[idx] = c;
                                r.op = jct_pkg::OP_UPDATE;
                            end
                            break;
                        end
                    end
                end
                if (it.new_job != '0 && q_head[m] != q_tail[m]) begin
                    s = free_slots[m*QLEN+q_head[m]];
                    q_head[m] = (q_head[m] == NSLOT) ? '0 : q_head[m] + 4'd1;
                    if (s < NSLOT) begin
                        slot_job[m*NSLOT+s]    = it.new_job;
                        slot_credit[m*NSLOT+s] = it.new_credit;
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_tick_result got);
            t_tick_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result job_id %h op %0d freed %0d",
                         $time, got.job_id, got.op, got.freed);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.job_id !== want.job_id) begin
                $display("%0t: job_id mismatch, expected %h, got %h",
                         $time, want.job_id, got.job_id);
                errors++;
            end
            if (got.op !== want.op) begin
                $display("%0t: operation mismatch, expected %0d, got %0d",
                         $time, want.op, got.op);
                errors++;
            end
            if (got.freed !== want.freed) begin
                $display("%0t: slot_freed mismatch, expected %0d, got %0d",
                         $time, want.freed, got.freed);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // random job currently held in a machine's table
        function bit pick_live(int m, output logic [JOB_W-1:0] id);
            int live [$];
            id = '0;
            if (m >= NMACH)
                return 1'b0;
            for (int k = 0; k < NSLOT; k++)
                if (slot_job[m*NSLOT+k] != '0)
                    live.push_back(m*NSLOT + k);
            if (live.size() == 0)
                return 1'b0;
            id = slot_job[live[$urandom_range(live.size()-1)]];
            return 1'b1;
        endfunction
    endclass

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // top_job[31:0], new_job[63:32], new_credit[71:64]
    logic [2:0]  s_tuser  = '0;   // machine[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // job_id[31:0]
    logic [2:0]  m_tuser;         // operation[1:0], slot_freed[2]

    credit_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;
    int hold_left    = 0;
    int idle_cycles  = 0;

    job_credit_table_update u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each transaction, then pick the next ready
    always @(posedge i_clk) begin : result_side
        t_tick_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.job_id = m_tdata;
            got.op     = m_tuser[1:0];
            got.freed  = m_tuser[2];
            sb.check_result(got);
        end
        if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_tick_item mk_tick(int m, logic [JOB_W-1:0] top,
                                           logic [JOB_W-1:0] nj, logic [CRED_W-1:0] c);
        t_tick_item it;
        it.machine    = MACH_W'(m);
        it.top_job    = top;
        it.new_job    = nj;
        it.new_credit = c;
        return it;
    endfunction

    // mostly ticks on live jobs so tables fill, drain and recycle slots
    function automatic t_tick_item random_tick();
        t_tick_item       it;
        logic [JOB_W-1:0] live;
        int               roll;
        if ($urandom_range(99) < 7)
            it.machine = MACH_W'($urandom_range(7, 5));
        else
            it.machine = MACH_W'($urandom_range(4));
        roll = $urandom_range(99);
        if (roll < 75 && sb.pick_live(it.machine, live))
            it.top_job = live;
        else if (roll < 85)
            it.top_job = '0;
        else
            it.top_job = $urandom;
        roll = $urandom_range(99);
        if (roll < 50) begin
            do it.new_job = $urandom; while (it.new_job == '0);
        end else if (roll < 55 && sb.pick_live(it.machine, live)) begin
            it.new_job = live;
        end else begin
            it.new_job = '0;
        end
        roll = $urandom_range(99);
        if (roll < 75)
            it.new_credit = CRED_W'($urandom_range(3, 1));
        else if (roll < 85)
            it.new_credit = '0;
        else
            it.new_credit = CRED_W'($urandom_range(255));
        return it;
    endfunction

    task automatic send_tick(input t_tick_item it);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.machine;
        s_tdata  <= {it.new_credit, it.new_job, it.top_job};
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty tick, then extremes of ids and credit
        send_tick(mk_tick(0, 32'h0, 32'h0, 8'h00));
        send_tick(mk_tick(0, 32'h0, 32'hFFFF_FFFF, 8'hFF));
        send_tick(mk_tick(0, 32'hFFFF_FFFF, 32'h0, 8'h00));
        send_tick(mk_tick(0, 32'h0, 32'h1, 8'h01));
        send_tick(mk_tick(0, 32'h1, 32'h0, 8'h00));
        // zero credit wraps to 255
        send_tick(mk_tick(0, 32'h0, 32'h2, 8'h00));
        send_tick(mk_tick(0, 32'h2, 32'h0, 8'h00));
        // same id in two slots
        send_tick(mk_tick(1, 32'h0, 32'h5A5A_A5A5, 8'h02));
        send_tick(mk_tick(1, 32'h0, 32'h5A5A_A5A5, 8'h01));
        repeat (3) send_tick(mk_tick(1, 32'h5A5A_A5A5, 32'h0, 8'h00));
        // machine out of range
        send_tick(mk_tick(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        // free and install in one transaction
        send_tick(mk_tick(2, 32'h0, 32'h7, 8'h01));
        send_tick(mk_tick(2, 32'h7, 32'h8, 8'h03));
        // exhaust the free queue, last install is dropped
        for (int i = 0; i < 9; i++)
            send_tick(mk_tick(0, 32'h0, 32'h100 + i, 8'h05));
        send_tick(mk_tick(0, 32'h108, 32'h0, 8'h00));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_req     = 1'b1;
                end
                1: begin
                    tx_idle_pct  = 45;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 45;
                end
                default: begin
                    tx_idle_pct  = 30;
                    rx_stall_pct = 30;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_tick(random_tick());
            if (phase == 1)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
src/jct_pkg.sv
src/jct_ram.sv
src/jct_ctrl.sv
src/jct_dp.sv
src/job_credit_table_update.sv
tb/testbench.sv
